### rtl/rmpd_pkg.sv
// Shared types, codes and fixed-point constants for the rumble motor driver.
`default_nettype none
package rmpd_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_TICK      = 2'd0;
    localparam t_op OP_START     = 2'd1;
    localparam t_op OP_START_DLY = 2'd2;
    localparam t_op OP_STOP_ALL  = 2'd3;

    localparam logic CFG_PAD_MASK    = 1'b0;
    localparam logic CFG_ACTIVE_PADS = 1'b1;

    localparam int          MOTOR_W         = 4;
    localparam logic [17:0] PULSE_THRESHOLD = 18'd25600;
    localparam logic [17:0] ACC_MAX         = 18'd262143;
    localparam logic [1:0]  STOP_TICKS      = 2'd3;
    localparam logic [15:0] INERTIA_MAX     = 16'd32768;
    localparam logic [32:0] ROUND_HALF      = 33'd8192;

    // Per-channel strobes for the item leaving the input register.
    typedef struct packed {
        logic tick;
        logic load_start;
        logic load_pend;
        logic stop_all;
    } t_ch_ctl;

    typedef struct packed {
        logic running_next;
        logic busy;
        logic start;
        logic stop;
    } t_ch_stat;

    function automatic logic [15:0] clamp_inertia(input logic [15:0] v);
        clamp_inertia = (v > INERTIA_MAX) ? INERTIA_MAX : v;
    endfunction

endpackage
`default_nettype wire

### rtl/rmpd_if.sv
// Valid/ready stream interfaces for request and result items.
`default_nettype none
interface rmpd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  pad_index;
    logic [15:0] rate;
    logic [15:0] inertia;
    logic [14:0] lifetime;
    logic [14:0] delay_ticks;

    modport source (output valid, op, pad_index, rate, inertia, lifetime, delay_ticks,
                    input ready);
    modport sink   (input valid, op, pad_index, rate, inertia, lifetime, delay_ticks,
                    output ready);
endinterface

interface rmpd_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] motor_on;
    logic [3:0] start_issued;
    logic [3:0] stop_issued;
    logic       accepted;

    modport source (output valid, motor_on, start_issued, stop_issued, accepted,
                    input ready);
    modport sink   (input valid, motor_on, start_issued, stop_issued, accepted,
                    output ready);
endinterface
`default_nettype wire

### rtl/rumble_motor_pulse_density_driver.sv
// Top level: input register, per-pad channels, result register, config registers.
// A request passes through the input register and then the result register, which holds
// its result until the response side takes it. Throughput: one item per cycle while results
// are taken; every channel updates in parallel with its own multiplier.
// Reset (synchronous, active low) clears all channel state, empties both registers,
// and sets the pad mask to 0 and the serviced pad count to 1.
`default_nettype none
module rumble_motor_pulse_density_driver #(
    parameter int NUM_PADS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_idx,
    input  wire logic [3:0] i_cfg_data,
    rmpd_req_if.sink   i_req,
    rmpd_rsp_if.source o_rsp
);
    import rmpd_pkg::*;

    logic [3:0]  r_pad_mask;
    logic [2:0]  r_active_pads;

    logic        r_in_vld;
    t_op         r_op;
    logic [1:0]  r_pad;
    logic [15:0] r_rate;
    logic [15:0] r_inertia;
    logic [14:0] r_life;
    logic [14:0] r_delay;

    logic        r_out_vld;
    logic [MOTOR_W-1:0] r_motor_on;
    logic [MOTOR_W-1:0] r_start;
    logic [MOTOR_W-1:0] r_stop;
    logic        r_accepted;

    logic        adv;
    logic        take_in;
    logic        pad_in_range;
    logic        start_ok;
    logic        is_start;
    logic [3:0]  busy4;

    t_ch_ctl     ch_ctl  [NUM_PADS];
    t_ch_stat    ch_stat [NUM_PADS];

    logic [MOTOR_W-1:0] on_vec;
    logic [MOTOR_W-1:0] start_vec;
    logic [MOTOR_W-1:0] stop_vec;

    // Advance the input register into the result register when the latter frees up.
    assign adv     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign take_in = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mask    <= 4'd0;
            r_active_pads <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAD_MASK:    r_pad_mask    <= i_cfg_data;
                CFG_ACTIVE_PADS: r_active_pads <= i_cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take_in) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_op      <= i_req.op;
            r_pad     <= i_req.pad_index;
            r_rate    <= i_req.rate;
            r_inertia <= i_req.inertia;
            r_life    <= i_req.lifetime;
            r_delay   <= i_req.delay_ticks;
        end
    end

    // Pads beyond the channel count read as busy so a start there is refused.
    for (genvar j = 0; j < 4; j++) begin : g_busy
        if (j < NUM_PADS) begin : g_real
            assign busy4[j] = ch_stat[j].busy;
        end else begin : g_none
            assign busy4[j] = 1'b1;
        end
    end

    assign pad_in_range = ({2'b00, r_pad} < 4'(NUM_PADS));
    assign is_start     = (r_op == OP_START) || (r_op == OP_START_DLY);
    assign start_ok     = is_start && pad_in_range && r_pad_mask[r_pad] && !busy4[r_pad];

    for (genvar g = 0; g < NUM_PADS; g++) begin : g_ch
        logic has_motor;
        logic serviced;
        logic addressed;

        if (g < 4) begin : g_mask
            assign has_motor = r_pad_mask[g];
        end else begin : g_nomask
            assign has_motor = 1'b0;
        end

        assign serviced  = (3'(g) < r_active_pads) && has_motor;
        assign addressed = ({1'b0, r_pad} == 3'(g));

        assign ch_ctl[g].tick       = adv && (r_op == OP_TICK) && serviced;
        assign ch_ctl[g].load_start = adv && (r_op == OP_START) && start_ok && addressed;
        assign ch_ctl[g].load_pend  = adv && (r_op == OP_START_DLY) && start_ok && addressed;
        assign ch_ctl[g].stop_all   = adv && (r_op == OP_STOP_ALL) && serviced;

        rmpd_channel u_channel (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ch_ctl[g]),
            .i_rate     (r_rate),
            .i_inertia  (r_inertia),
            .i_lifetime (r_life),
            .i_delay    (r_delay),
            .o_stat     (ch_stat[g])
        );
    end

    for (genvar k = 0; k < MOTOR_W; k++) begin : g_out
        if (k < NUM_PADS) begin : g_real
            assign on_vec[k]    = ch_stat[k].running_next;
            assign start_vec[k] = ch_stat[k].start;
            assign stop_vec[k]  = ch_stat[k].stop;
        end else begin : g_none
            assign on_vec[k]    = 1'b0;
            assign start_vec[k] = 1'b0;
            assign stop_vec[k]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_motor_on <= on_vec;
            r_start    <= start_vec;
            r_stop     <= stop_vec;
            r_accepted <= start_ok;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.motor_on     = r_motor_on;
    assign o_rsp.start_issued = r_start;
    assign o_rsp.stop_issued  = r_stop;
    assign o_rsp.accepted     = r_accepted;

endmodule
`default_nettype wire

### rtl/rmpd_channel.sv
// One rumble channel: state registers and the per-tick update.
`default_nettype none
module rmpd_channel (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rmpd_pkg::t_ch_ctl i_ctl,
    input  wire logic [15:0]       i_rate,
    input  wire logic [15:0]       i_inertia,
    input  wire logic [14:0]       i_lifetime,
    input  wire logic [14:0]       i_delay,
    output rmpd_pkg::t_ch_stat     o_stat
);
    import rmpd_pkg::*;

    logic [14:0] r_run,     n_run;
    logic [1:0]  r_stop,    n_stop;
    logic [15:0] r_rate,    n_rate;
    logic [15:0] r_mult,    n_mult;
    logic [17:0] r_acc,     n_acc;
    logic        r_running, n_running;
    logic [14:0] r_plife,   n_plife;
    logic [15:0] r_prate,   n_prate;
    logic [15:0] r_pmult,   n_pmult;
    logic [14:0] r_pdelay,  n_pdelay;

    logic        fire;
    logic [14:0] run_e;
    logic [1:0]  stop_e;
    logic [15:0] rate_e;
    logic [15:0] mult_e;
    logic [31:0] prod;
    logic [32:0] prod_rnd;
    logic [15:0] rate_scaled;
    logic [18:0] acc_sum;
    logic [17:0] acc_sat;
    logic        start_p;
    logic        stop_p;

    // A pending start fires when its delay has run out and the channel is idle.
    assign fire   = i_ctl.tick && (r_plife != 15'd0) && (r_pdelay == 15'd0) && (r_run == 15'd0);
    assign run_e  = fire ? r_plife : r_run;
    assign stop_e = fire ? STOP_TICKS : r_stop;
    assign rate_e = fire ? r_prate : r_rate;
    assign mult_e = fire ? r_pmult : r_mult;

    assign prod        = rate_e * mult_e;
    assign prod_rnd    = {1'b0, prod} + ROUND_HALF;
    assign rate_scaled = (prod_rnd[32:30] != 3'd0) ? 16'hFFFF : prod_rnd[29:14];

    assign acc_sum = {1'b0, r_acc} + {3'b000, rate_e};
    assign acc_sat = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[17:0];

    always_comb begin
        n_run     = r_run;
        n_stop    = r_stop;
        n_rate    = r_rate;
        n_mult    = r_mult;
        n_acc     = r_acc;
        n_running = r_running;
        n_plife   = r_plife;
        n_prate   = r_prate;
        n_pmult   = r_pmult;
        n_pdelay  = r_pdelay;
        start_p   = 1'b0;
        stop_p    = 1'b0;
        if (i_ctl.tick) begin
            if (r_plife != 15'd0) begin
                if (r_pdelay == 15'd0) begin
                    n_plife = 15'd0;
                end else begin
                    n_pdelay = r_pdelay - 15'd1;
                end
            end
            if (run_e != 15'd0) begin
                n_run  = run_e - 15'd1;
                n_stop = stop_e;
                n_mult = mult_e;
                n_rate = rate_scaled;
                if (acc_sat >= PULSE_THRESHOLD) begin
                    start_p   = !r_running;
                    n_running = 1'b1;
                    n_acc     = acc_sat - PULSE_THRESHOLD;
                end else begin
                    stop_p    = r_running;
                    n_running = 1'b0;
                    n_acc     = acc_sat;
                end
            end else if (r_stop != 2'd0) begin
                stop_p    = 1'b1;
                n_running = 1'b0;
                n_stop    = r_stop - 2'd1;
                if (r_stop == 2'd1) begin
                    n_rate = 16'd0;
                    n_acc  = 18'd0;
                end else if (r_acc > PULSE_THRESHOLD) begin
                    n_acc = r_acc - PULSE_THRESHOLD;
                end
            end
        end else if (i_ctl.load_start) begin
            n_stop = STOP_TICKS;
            n_run  = i_lifetime;
            n_mult = clamp_inertia(i_inertia);
            n_rate = i_rate;
        end else if (i_ctl.load_pend) begin
            n_plife  = i_lifetime;
            n_prate  = i_rate;
            n_pmult  = clamp_inertia(i_inertia);
            n_pdelay = i_delay;
        end else if (i_ctl.stop_all) begin
            n_run = 15'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_stop    <= '0;
            r_rate    <= '0;
            r_mult    <= '0;
            r_acc     <= '0;
            r_running <= 1'b0;
            r_plife   <= '0;
            r_prate   <= '0;
            r_pmult   <= '0;
            r_pdelay  <= '0;
        end else begin
            r_run     <= n_run;
            r_stop    <= n_stop;
            r_rate    <= n_rate;
            r_mult    <= n_mult;
            r_acc     <= n_acc;
            r_running <= n_running;
            r_plife   <= n_plife;
            r_prate   <= n_prate;
            r_pmult   <= n_pmult;
            r_pdelay  <= n_pdelay;
        end
    end

    assign o_stat.running_next = n_running;
    assign o_stat.busy         = (r_run != 15'd0);
    assign o_stat.start        = start_p;
    assign o_stat.stop         = stop_p;

endmodule
`default_nettype wire

### tb/rmpd_motor_checker.sv
// Checker for the rumble motor driver: watches both streams, predicts each result and compares.
module rmpd_motor_checker #(
    parameter int NUM_PADS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    rmpd_req_if        i_req,
    rmpd_rsp_if        i_rsp,
    output int         o_mismatches,
    output int         o_outstanding,
    output int         o_results,
    output int         o_accepts,
    output int         o_motor_starts
);
    import rmpd_pkg::*;

    typedef struct packed {
        logic [3:0] motor_on;
        logic [3:0] start_issued;
        logic [3:0] stop_issued;
        logic       accepted;
    } t_motor_result;

    t_motor_result expected_q[$];

    logic [3:0]  pad_mask;
    logic [2:0]  active_cfg;

    logic [14:0] run_left[NUM_PADS];
    logic [1:0]  stop_left[NUM_PADS];
    logic [15:0] cur_rate[NUM_PADS];
    logic [15:0] rate_mult[NUM_PADS];
    logic [17:0] pulse_acc[NUM_PADS];
    logic        running[NUM_PADS];
    logic [14:0] pend_life[NUM_PADS];
    logic [15:0] pend_rate[NUM_PADS];
    logic [15:0] pend_mult[NUM_PADS];
    logic [14:0] pend_delay[NUM_PADS];

    function automatic logic [15:0] limit_inertia(input logic [15:0] v);
        return (v > INERTIA_MAX) ? INERTIA_MAX : v;
    endfunction

    task automatic load_channel(input int p, input logic [15:0] rate,
                                input logic [15:0] mult, input logic [14:0] life);
        stop_left[p] = STOP_TICKS;
        run_left[p]  = life;
        rate_mult[p] = limit_inertia(mult);
        cur_rate[p]  = rate;
    endtask

    task automatic predict_item(input t_op op, input logic [1:0] pad, input logic [15:0] rate,
                                input logic [15:0] inertia, input logic [14:0] life,
                                input logic [14:0] delay, output t_motor_result res);
        int          n;
        logic [18:0] acc;
        logic [32:0] prod;
        logic        can_start;
        res = '0;
        n = (active_cfg > NUM_PADS) ? NUM_PADS : active_cfg;
        can_start = (pad < NUM_PADS) && pad_mask[pad] && (run_left[pad] == 0);
        case (op)
            OP_TICK: begin
                for (int p = 0; p < NUM_PADS; p++) begin
                    if (p < n && pad_mask[p]) begin
                        // Fire or count down a parked start; a busy channel drops it.
                        if (pend_life[p] != 0) begin
                            if (pend_delay[p] == 0) begin
                                if (run_left[p] == 0)
                                    load_channel(p, pend_rate[p], pend_mult[p], pend_life[p]);
                                pend_life[p] = '0;
                            end else begin
                                pend_delay[p] = pend_delay[p] - 1'b1;
                            end
                        end
                        if (run_left[p] != 0) begin
                            run_left[p] = run_left[p] - 1'b1;
                            acc = {1'b0, pulse_acc[p]} + cur_rate[p];
                            if (acc > ACC_MAX)
                                acc = ACC_MAX;
                            prod = (33'(cur_rate[p]) * 33'(rate_mult[p]) + ROUND_HALF) >> 14;
                            cur_rate[p] = (prod > 33'hFFFF) ? 16'hFFFF : prod[15:0];
                            if (acc >= PULSE_THRESHOLD) begin
                                if (!running[p]) begin
                                    res.start_issued[p] = 1'b1;
                                    running[p] = 1'b1;
                                end
                                acc = acc - PULSE_THRESHOLD;
                            end else begin
                                if (running[p])
                                    res.stop_issued[p] = 1'b1;
                                running[p] = 1'b0;
                            end
                            pulse_acc[p] = acc[17:0];
                        end else if (stop_left[p] != 0) begin
                            res.stop_issued[p] = 1'b1;
                            running[p] = 1'b0;
                            if (pulse_acc[p] > PULSE_THRESHOLD)
                                pulse_acc[p] = pulse_acc[p] - PULSE_THRESHOLD;
                            stop_left[p] = stop_left[p] - 1'b1;
                            if (stop_left[p] == 0) begin
                                cur_rate[p]  = '0;
                                pulse_acc[p] = '0;
                            end
                        end
                    end
                end
            end
            OP_START: begin
                if (can_start) begin
                    load_channel(pad, rate, inertia, life);
                    res.accepted = 1'b1;
                end
            end
            OP_START_DLY: begin
                if (can_start) begin
                    pend_life[pad]  = life;
                    pend_rate[pad]  = rate;
                    pend_mult[pad]  = limit_inertia(inertia);
                    pend_delay[pad] = delay;
                    res.accepted    = 1'b1;
                end
            end
            default: begin
                // Stop-all keeps pending starts and stop ticks.
                for (int p = 0; p < NUM_PADS; p++)
                    if (p < n && pad_mask[p])
                        run_left[p] = '0;
            end
        endcase
        for (int p = 0; p < NUM_PADS && p < 4; p++)
            res.motor_on[p] = running[p];
    endtask

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_motor_result want;
        if (!i_rst_n) begin
            pad_mask   = '0;
            active_cfg = 3'd1;
            for (int p = 0; p < NUM_PADS; p++) begin
                run_left[p]   = '0;
                stop_left[p]  = '0;
                cur_rate[p]   = '0;
                rate_mult[p]  = '0;
                pulse_acc[p]  = '0;
                running[p]    = 1'b0;
                pend_life[p]  = '0;
                pend_rate[p]  = '0;
                pend_mult[p]  = '0;
                pend_delay[p] = '0;
            end
            expected_q.delete();
            o_mismatches   = 0;
            o_results      = 0;
            o_accepts      = 0;
            o_motor_starts = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PAD_MASK)
                    pad_mask = i_cfg_data;
                else
                    active_cfg = i_cfg_data[2:0];
            end
            if (i_req.valid && i_req.ready) begin
                predict_item(t_op'(i_req.op), i_req.pad_index, i_req.rate, i_req.inertia,
                             i_req.lifetime, i_req.delay_ticks, want);
                expected_q.push_back(want);
                o_accepts      += want.accepted;
                o_motor_starts += $countones(want.start_issued);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h/%h/%h/%b",
                             $time, i_rsp.motor_on, i_rsp.start_issued, i_rsp.stop_issued,
                             i_rsp.accepted);
                    o_mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("motor_on", want.motor_on, i_rsp.motor_on);
                    check_field("start_issued", want.start_issued, i_rsp.start_issued);
                    check_field("stop_issued", want.stop_issued, i_rsp.stop_issued);
                    check_field("accepted", {3'b0, want.accepted}, {3'b0, i_rsp.accepted});
                end
            end
        end
        o_outstanding = expected_q.size();
    end

endmodule

### tb/rumble_motor_pulse_density_driver_tb.sv
// Stimulus and verdict for the rumble motor driver, with the result checker beside the block.
module rumble_motor_pulse_density_driver_tb;
    import rmpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;
    localparam int NUM_CONFIGS = 6;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [3:0] i_cfg_data;

    int mismatches;
    int outstanding;
    int results_seen;
    int starts_taken;
    int motor_starts;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    // Per-phase register values, idle and stall rates and item counts.
    logic [3:0] phase_mask[NUM_CONFIGS]  = '{4'hF, 4'h5, 4'hE, 4'h0, 4'hF, 4'hB};
    logic [2:0] phase_active[NUM_CONFIGS] = '{3'd4, 3'd7, 3'd2, 3'd0, 3'd3, 3'd1};
    int         phase_idle[NUM_CONFIGS]  = '{0, 59, 0, 22, 22, 0};
    int         phase_stall[NUM_CONFIGS] = '{0, 0, 59, 22, 22, 0};
    int         phase_items[NUM_CONFIGS] = '{150, 130, 130, 40, 150, 150};

    rmpd_req_if req_ch ();
    rmpd_rsp_if rsp_ch ();

    rumble_motor_pulse_density_driver #(.NUM_PADS(4)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    rmpd_motor_checker #(.NUM_PADS(4)) motor_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_results      (results_seen),
        .o_accepts      (starts_taken),
        .o_motor_starts (motor_starts)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input t_op op, input logic [1:0] pad, input logic [15:0] rate,
                             input logic [15:0] inertia, input logic [14:0] life,
                             input logic [14:0] delay);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.pad_index   <= pad;
        req_ch.rate        <= rate;
        req_ch.inertia     <= inertia;
        req_ch.lifetime    <= life;
        req_ch.delay_ticks <= delay;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  15'($urandom), 15'($urandom));
    endtask

    task automatic send_random_item();
        int unsigned sel;
        t_op         op;
        logic [15:0] rate;
        logic [15:0] inertia;
        logic [14:0] life;
        logic [14:0] delay;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            op = OP_TICK;
        else if (sel < 76)
            op = OP_START;
        else if (sel < 95)
            op = OP_START_DLY;
        else
            op = OP_STOP_ALL;
        sel = $urandom_range(0, 9);
        rate = (sel < 6) ? 16'($urandom_range(2560, 25600)) :
               (sel < 8) ? 16'($urandom_range(0, 2559)) : 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 9);
        inertia = (sel < 5) ? 16'($urandom_range(14000, 18000)) :
                  (sel < 7) ? 16'($urandom_range(0, 32768)) : 16'($urandom_range(0, 65535));
        // Keep most runs short so channels cycle through start, run and stop ticks.
        sel = $urandom_range(0, 9);
        life = (sel < 8) ? 15'($urandom_range(0, 12)) :
               (sel < 9) ? 15'($urandom_range(13, 200)) : 15'($urandom_range(0, 32767));
        sel = $urandom_range(0, 9);
        delay = (sel < 8) ? 15'($urandom_range(0, 6)) :
                (sel < 9) ? 15'($urandom_range(7, 50)) : 15'($urandom_range(0, 32767));
        send_item(op, 2'($urandom_range(0, 3)), rate, inertia, life, delay);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [3:0] mask, input logic [2:0] active);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PAD_MASK;
        i_cfg_data <= mask;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ACTIVE_PADS;
        i_cfg_data <= {1'b0, active};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_PAD_MASK;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_TICK;
        req_ch.pad_index   = '0;
        req_ch.rate        = '0;
        req_ch.inertia     = '0;
        req_ch.lifetime    = '0;
        req_ch.delay_ticks = '0;
        rsp_ch.ready       = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        cycles             = 0;
        items_sent         = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, refusals, zero lifetime, overwrite and dropped starts.
        write_config(4'hF, 3'd4);
        send_item(OP_START, 2'd0, 16'hFFFF, 16'hFFFF, 15'd2, 15'h7FFF);
        send_item(OP_START, 2'd0, 16'h0001, 16'h0000, 15'h7FFF, 15'd0);
        send_item(OP_START, 2'd1, 16'h6400, 16'h4000, 15'd0, 15'd0);
        send_item(OP_START, 2'd2, 16'h0000, 16'h0000, 15'h7FFF, 15'd0);
        send_item(OP_START_DLY, 2'd3, 16'h3000, 16'h4000, 15'd3, 15'd0);
        send_item(OP_START_DLY, 2'd3, 16'h7000, 16'h5000, 15'd5, 15'd2);
        send_item(OP_START_DLY, 2'd1, 16'h1000, 16'h4000, 15'd0, 15'd0);
        repeat (3) send_tick();
        // Park a start on pad 1, then start it directly so the parked one finds it busy.
        send_item(OP_START_DLY, 2'd1, 16'h2000, 16'h4000, 15'd4, 15'd1);
        send_item(OP_START, 2'd1, 16'h5000, 16'h4400, 15'd8, 15'd0);
        repeat (2) send_tick();
        send_item(OP_STOP_ALL, 2'd3, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        repeat (4) send_tick();

        for (int ph = 0; ph < NUM_CONFIGS; ph++) begin
            drain_results();
            write_config(phase_mask[ph], phase_active[ph]);
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int k = 0; k < phase_items[ph]; k++) begin
                send_random_item();
                // Hold the sender once until every result is back.
                if (ph == 2 && k == phase_items[ph] / 2)
                    drain_results();
            end
        end

        drain_results();
        $display("Drove %0d requests over %0d register settings with varied idling;",
                 items_sent, NUM_CONFIGS + 1);
        $display("checked %0d results, %0d starts taken, %0d motor start commands.",
                 results_seen, starts_taken, motor_starts);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
